@@ rtl/npps_pkg.sv @@
// ----------------------------------------------------------------------------
// npps_pkg
// Types, constants and microcode for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package npps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ARR_W         = 16;
  localparam int TIME_W        = 21;
  localparam int SUM_W         = 27;
  localparam int JOB_INDEX_W   = 6;

  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [ARR_W-1:0]  ARR_MIN_INIT = {ARR_W{1'b1}};

  typedef struct packed {
    logic [15:0]        arrival;
    logic [15:0]        burst;
    logic signed [15:0] urgency;
    logic               final_job;
  } job_in_t;

  typedef struct packed {
    logic [JOB_INDEX_W-1:0] job_index;
    logic [TIME_W-1:0]      completion;
    logic [TIME_W-1:0]      turnaround;
    logic [TIME_W-1:0]      waiting;
    logic [TIME_W-1:0]      response;
    logic [SUM_W-1:0]       turnaround_sum;
    logic [SUM_W-1:0]       waiting_sum;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic [15:0]        arrival;
    logic [15:0]        burst;
    logic signed [15:0] urgency;
  } job_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
  } time_entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_EVAL,
    OP_COMMIT,
    OP_CLOCK_JUMP,
    OP_OUT_INIT,
    OP_CALC1,
    OP_CALC2,
    OP_EMIT,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_FINAL,
    C_NOT_LAST,
    C_NOT_FOUND,
    C_NOT_ALL_DONE
  } cond_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_DECIDE,
    S_COMMIT,
    S_OUT_INIT,
    S_OUT_RD,
    S_OUT_CALC1,
    S_OUT_CALC2,
    S_OUT_EMIT,
    S_FINISH,
    S_JUMP
  } step_t;

  typedef struct packed {
    logic busy;
    op_t  op;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic load_final;
    logic last_idx;
    logic found;
    logic all_done;
  } flags_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    unique case (step)
      S_LOAD:      w = '{ctl: '{1'b0, OP_LOAD},       cond: C_NO_FINAL,     target: S_LOAD};
      S_SCAN_INIT: w = '{ctl: '{1'b1, OP_SCAN_INIT},  cond: C_NONE,         target: S_LOAD};
      S_SCAN_RD:   w = '{ctl: '{1'b1, OP_NONE},       cond: C_NONE,         target: S_LOAD};
      S_SCAN_EVAL: w = '{ctl: '{1'b1, OP_EVAL},       cond: C_NOT_LAST,     target: S_SCAN_RD};
      S_DECIDE:    w = '{ctl: '{1'b1, OP_NONE},       cond: C_NOT_FOUND,    target: S_JUMP};
      S_COMMIT:    w = '{ctl: '{1'b1, OP_COMMIT},     cond: C_NOT_ALL_DONE, target: S_SCAN_INIT};
      S_OUT_INIT:  w = '{ctl: '{1'b1, OP_OUT_INIT},   cond: C_NONE,         target: S_LOAD};
      S_OUT_RD:    w = '{ctl: '{1'b1, OP_NONE},       cond: C_NONE,         target: S_LOAD};
      S_OUT_CALC1: w = '{ctl: '{1'b1, OP_CALC1},      cond: C_NONE,         target: S_LOAD};
      S_OUT_CALC2: w = '{ctl: '{1'b1, OP_CALC2},      cond: C_NONE,         target: S_LOAD};
      S_OUT_EMIT:  w = '{ctl: '{1'b1, OP_EMIT},       cond: C_NOT_LAST,     target: S_OUT_RD};
      S_FINISH:    w = '{ctl: '{1'b1, OP_FINISH},     cond: C_ALWAYS,       target: S_LOAD};
      S_JUMP:      w = '{ctl: '{1'b1, OP_CLOCK_JUMP}, cond: C_ALWAYS,       target: S_SCAN_INIT};
      default:     w = '{ctl: '{1'b1, OP_FINISH},     cond: C_ALWAYS,       target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/nonpreemptive_priority_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_top
// Loads job descriptors, runs non-preemptive priority scheduling, reports
// per-job times and the run totals.
//
//   channel   handshake           payload    transfer
//   job in    start / busy        job        start high while busy low
//   result    strobe              result     every cycle strobe is high
//
// A job loads while busy is low. The job marked final starts the run: each
// scheduling decision scans every stored job through the registered store
// read, and a pass that finds nothing arrived costs one extra pass. Results
// then follow, one per stored job.
// rst clears the sequencer, counters and done flags; the stores keep no reset.
// Results go out one per strobe and cannot be held off.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_top
  import npps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  job_in_t job,
  output logic    strobe,
  output result_t result
);

  ctl_t   ctl;
  flags_t flags;

  npps_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  npps_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .start  (start),
    .job    (job),
    .flags  (flags),
    .strobe (strobe),
    .result (result)
  );

  assign busy = ctl.busy;

endmodule

@@ rtl/npps_ram.sv @@
// ----------------------------------------------------------------------------
// npps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/npps_seq.sv @@
// ----------------------------------------------------------------------------
// npps_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module npps_seq
  import npps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctl_t   ctl
);

  step_t  step;
  step_t  step_next;
  uword_t uword;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_LOAD;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uword = ucode_rom(step);
    unique case (uword.cond)
      C_NONE:         take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_FINAL:     take = !flags.load_final;
      C_NOT_LAST:     take = !flags.last_idx;
      C_NOT_FOUND:    take = !flags.found;
      C_NOT_ALL_DONE: take = !flags.all_done;
      default:        take = 1'b1;
    endcase
    step_next = take ? uword.target : step_t'(step + 4'd1);
    ctl       = uword.ctl;
  end

endmodule

@@ rtl/npps_dp.sv @@
// ----------------------------------------------------------------------------
// npps_dp
// Scheduler datapath: job and time stores, scan, commit and result math.
// ----------------------------------------------------------------------------
module npps_dp
  import npps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  ctl_t    ctl,
  input  logic    start,
  input  job_in_t job,
  output flags_t  flags,
  output logic    strobe,
  output result_t result
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  logic [CNT_W-1:0]   job_count;
  logic [CNT_W-1:0]   finished;
  logic [TIME_W-1:0]  clock_now;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   best;
  logic signed [15:0] best_urg;
  logic [15:0]        best_burst;
  logic               found;
  logic [ARR_W-1:0]   min_arr;
  logic [MAX_PROCS-1:0] done_flags;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  resp;
  logic [TIME_W-1:0]  wt;
  logic [SUM_W-1:0]   tat_sum;
  logic [SUM_W-1:0]   wt_sum;

  job_entry_t  job_rd;
  time_entry_t time_rd;
  job_entry_t  job_wr;
  time_entry_t time_wr;
  logic        load_we;
  logic        load_ok;

  logic [TIME_W:0]   clk_sum;
  logic [TIME_W-1:0] clock_next;
  logic              elig;
  logic              cur_done;
  logic [SUM_W:0]    tat_acc;
  logic [SUM_W:0]    wt_acc;
  logic [SUM_W-1:0]  wt_sum_next;
  logic [TIME_W-1:0] arr_t;

  // job store: written at load, read by the scan and the result pass
  npps_ram #(.WIDTH($bits(job_entry_t)), .DEPTH(MAX_PROCS)) u_job_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (job_count[IDX_W-1:0]),
    .wdata (job_wr),
    .raddr (idx),
    .rdata (job_rd)
  );

  // start and finish times, written at commit
  npps_ram #(.WIDTH($bits(time_entry_t)), .DEPTH(MAX_PROCS)) u_time_ram (
    .clk   (clk),
    .we    (ctl.op == OP_COMMIT),
    .waddr (best),
    .wdata (time_wr),
    .raddr (idx),
    .rdata (time_rd)
  );

  always_comb begin
    load_ok  = start && (ctl.op == OP_LOAD);
    load_we  = load_ok && (job_count < CNT_MAX);
    job_wr   = '{arrival: job.arrival, burst: job.burst, urgency: job.urgency};

    clk_sum    = {1'b0, clock_now} + (TIME_W + 1)'(best_burst);
    clock_next = clk_sum[TIME_W] ? TIME_MAX : clk_sum[TIME_W-1:0];
    time_wr    = '{start: clock_now, finish: clock_next};

    cur_done = done_flags[idx];
    elig     = !cur_done && (TIME_W'(job_rd.arrival) <= clock_now);

    tat_acc     = {1'b0, tat_sum} + (SUM_W + 1)'(tat);
    wt_acc      = {1'b0, wt_sum} + (SUM_W + 1)'(wt);
    wt_sum_next = wt_acc[SUM_W] ? SUM_MAX : wt_acc[SUM_W-1:0];
    arr_t       = TIME_W'(job_rd.arrival);

    flags.load_final = load_ok && job.final_job;
    flags.last_idx   = CNT_W'(idx) == (job_count - CNT_W'(1));
    flags.found      = found;
    flags.all_done   = (finished + CNT_W'(1)) == job_count;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      finished   <= '0;
      clock_now  <= '0;
      done_flags <= '0;
      found      <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (ctl.op)
        OP_LOAD: begin
          if (load_we) begin
            job_count <= job_count + CNT_W'(1);
          end
        end
        OP_SCAN_INIT: found <= 1'b0;
        OP_EVAL: begin
          if (elig && (!found || (job_rd.urgency > best_urg))) begin
            found <= 1'b1;
          end
        end
        OP_COMMIT: begin
          clock_now        <= clock_next;
          done_flags[best] <= 1'b1;
          finished         <= finished + CNT_W'(1);
        end
        OP_CLOCK_JUMP: clock_now <= TIME_W'(min_arr);
        OP_EMIT: strobe <= 1'b1;
        OP_FINISH: begin
          job_count  <= '0;
          finished   <= '0;
          clock_now  <= '0;
          done_flags <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_SCAN_INIT: begin
        idx     <= '0;
        min_arr <= ARR_MIN_INIT;
      end
      OP_EVAL: begin
        if (elig && (!found || (job_rd.urgency > best_urg))) begin
          best       <= idx;
          best_urg   <= job_rd.urgency;
          best_burst <= job_rd.burst;
        end
        if (!cur_done && (job_rd.arrival < min_arr)) begin
          min_arr <= job_rd.arrival;
        end
        idx <= idx + IDX_W'(1);
      end
      OP_OUT_INIT: begin
        idx     <= '0;
        tat_sum <= '0;
        wt_sum  <= '0;
      end
      OP_CALC1: begin
        tat  <= (time_rd.finish >= arr_t) ? time_rd.finish - arr_t : '0;
        resp <= (time_rd.start >= arr_t) ? time_rd.start - arr_t : '0;
      end
      OP_CALC2: begin
        wt      <= (tat >= TIME_W'(job_rd.burst)) ? tat - TIME_W'(job_rd.burst) : '0;
        tat_sum <= tat_acc[SUM_W] ? SUM_MAX : tat_acc[SUM_W-1:0];
      end
      OP_EMIT: begin
        wt_sum                <= wt_sum_next;
        result.job_index      <= JOB_INDEX_W'(idx);
        result.completion     <= time_rd.finish;
        result.turnaround     <= tat;
        result.waiting        <= wt;
        result.response       <= resp;
        result.turnaround_sum <= flags.last_idx ? tat_sum : '0;
        result.waiting_sum    <= flags.last_idx ? wt_sum_next : '0;
        result.last_result    <= flags.last_idx;
        idx                   <= idx + IDX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ dv/tb_nonpreemptive_priority_scheduler_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_top
// Loads job sets into the scheduler, predicts the non-preemptive priority
// schedule of each set in a scoreboard, and checks every per-job result and
// the run totals field by field. A directed opening (extreme fields, priority
// ties, zero bursts, idle clock jumps, an overfull set whose final job is
// dropped) is followed by random sets with random sender gaps.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler_top;
  import npps_pkg::*;

  localparam int TARGET_JOBS = 380;
  localparam int CALM_FROM   = 320;

  class sched_scoreboard;
    logic [15:0]        arrival_mem [MAX_PROCS_DEF];
    logic [15:0]        burst_mem   [MAX_PROCS_DEF];
    logic signed [15:0] urgency_mem [MAX_PROCS_DEF];
    int                 n_stored;
    result_t            pending_results [$];
    int                 errors;

    function void note_job(job_in_t j);
      int unsigned start_t [MAX_PROCS_DEF];
      int unsigned finish_t [MAX_PROCS_DEF];
      bit          done [MAX_PROCS_DEF];
      int unsigned now;
      int unsigned earliest;
      int unsigned tat;
      int unsigned wt;
      int unsigned resp;
      int unsigned tat_sum;
      int unsigned wt_sum;
      int          finished;
      int          pick;
      bit          found;
      result_t     r;
      if (n_stored < MAX_PROCS_DEF) begin
        arrival_mem[n_stored] = j.arrival;
        burst_mem[n_stored]   = j.burst;
        urgency_mem[n_stored] = j.urgency;
        n_stored++;
      end
      if (!j.final_job) return;

      for (int i = 0; i < MAX_PROCS_DEF; i++) done[i] = 1'b0;
      now      = 0;
      finished = 0;
      while (finished < n_stored) begin
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < n_stored; i++) begin
          if (!done[i] && arrival_mem[i] <= now) begin
            if (!found || urgency_mem[i] > urgency_mem[pick]) begin
              pick  = i;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          // nothing arrived yet, jump ahead to the earliest pending arrival
          earliest = 32'(TIME_MAX);
          for (int i = 0; i < n_stored; i++)
            if (!done[i] && arrival_mem[i] < earliest) earliest = 32'(arrival_mem[i]);
          now = earliest;
        end else begin
          start_t[pick] = now;
          now = now + burst_mem[pick];
          if (now > TIME_MAX) now = 32'(TIME_MAX);
          finish_t[pick] = now;
          done[pick]     = 1'b1;
          finished++;
        end
      end

      tat_sum = 0;
      wt_sum  = 0;
      for (int i = 0; i < n_stored; i++) begin
        tat  = (finish_t[i] >= arrival_mem[i]) ? finish_t[i] - arrival_mem[i] : 0;
        wt   = (tat >= burst_mem[i]) ? tat - burst_mem[i] : 0;
        resp = (start_t[i] >= arrival_mem[i]) ? start_t[i] - arrival_mem[i] : 0;
        if (tat > TIME_MAX) tat = 32'(TIME_MAX);
        if (wt > TIME_MAX) wt = 32'(TIME_MAX);
        tat_sum = tat_sum + tat;
        wt_sum  = wt_sum + wt;
        if (tat_sum > SUM_MAX) tat_sum = 32'(SUM_MAX);
        if (wt_sum > SUM_MAX) wt_sum = 32'(SUM_MAX);
        r.job_index      = JOB_INDEX_W'(i);
        r.completion     = TIME_W'(finish_t[i]);
        r.turnaround     = TIME_W'(tat);
        r.waiting        = TIME_W'(wt);
        r.response       = TIME_W'(resp);
        r.last_result    = (i == n_stored - 1);
        r.turnaround_sum = r.last_result ? SUM_W'(tat_sum) : '0;
        r.waiting_sum    = r.last_result ? SUM_W'(wt_sum) : '0;
        pending_results = {pending_results, r};
      end
      n_stored = 0;
    endfunction

    function void field_check(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result for job %0d", got.job_index);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_check("job_index", 32'(want.job_index), 32'(got.job_index));
      field_check("completion", 32'(want.completion), 32'(got.completion));
      field_check("turnaround", 32'(want.turnaround), 32'(got.turnaround));
      field_check("waiting", 32'(want.waiting), 32'(got.waiting));
      field_check("response", 32'(want.response), 32'(got.response));
      field_check("turnaround_sum", 32'(want.turnaround_sum), 32'(got.turnaround_sum));
      field_check("waiting_sum", 32'(want.waiting_sum), 32'(got.waiting_sum));
      field_check("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  job_in_t         job;
  logic            strobe;
  result_t         result;
  sched_scoreboard sb;
  int              n_sent;

  nonpreemptive_priority_scheduler_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .job    (job),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && strobe === 1'b1) sb.check_result(result);
  end

  task automatic send_job(job_in_t j);
    @(negedge clk);
    start <= 1'b1;
    job   <= j;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_job(j);
    n_sent++;
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] extreme_or_any();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic job_in_t make_job(int mode, bit last);
    job_in_t j;
    case (mode)
      0: begin
        // dense small set: contention and priority ties
        j.arrival = 16'($urandom_range(0, 60));
        j.burst   = 16'($urandom_range(0, 25));
        j.urgency = 16'(int'($urandom_range(0, 8)) - 4);
      end
      1: begin
        j.arrival = 16'($urandom_range(0, 65535));
        j.burst   = 16'($urandom_range(0, 65535));
        j.urgency = 16'($urandom_range(0, 65535));
      end
      2: begin
        j.arrival = extreme_or_any();
        j.burst   = extreme_or_any();
        j.urgency = 16'h8000 ^ extreme_or_any();
      end
      default: begin
        j.arrival = 16'($urandom_range(0, 2000));
        j.burst   = 16'($urandom_range(0, 500));
        j.urgency = 16'($urandom_range(0, 65535));
      end
    endcase
    j.final_job = last;
    return j;
  endfunction

  initial begin
    job_in_t d;
    int      set_len;
    int      mode;
    int      n_sets;
    bit      calm;
    rst    = 1'b1;
    start  = 1'b0;
    job    = '0;
    n_sent = 0;
    sb     = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single late job with extreme fields: idle clock jump
    d = '{arrival: 16'hFFFF, burst: 16'hFFFF, urgency: 16'sh8000, final_job: 1'b1};
    send_job(d);

    // equal urgencies, a zero burst, a late high-priority arrival
    d = '{arrival: 16'd0, burst: 16'd0, urgency: 16'sd0, final_job: 1'b0};
    send_job(d);
    d = '{arrival: 16'd0, burst: 16'd5, urgency: 16'sd0, final_job: 1'b0};
    send_job(d);
    d = '{arrival: 16'd2, burst: 16'd3, urgency: 16'sh7FFF, final_job: 1'b1};
    send_job(d);

    // overfull set: the seventeenth job is dropped but still starts the run
    for (int i = 0; i < MAX_PROCS_DEF + 1; i++) begin
      d.arrival   = 16'(i);
      d.burst     = (i % 4 == 0) ? 16'hFFFF : 16'(i);
      d.urgency   = (i % 2 == 1) ? 16'sh7FFF : 16'sh8000;
      d.final_job = (i == MAX_PROCS_DEF);
      send_job(d);
    end
    wait_drained();

    n_sets = 0;
    while (n_sent < TARGET_JOBS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PROCS_DEF + 1, MAX_PROCS_DEF + 4)
                                            : $urandom_range(1, MAX_PROCS_DEF);
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
      calm = ($urandom_range(0, 2) == 0) || (n_sent >= CALM_FROM);
      for (int k = 0; k < set_len; k++) begin
        if (!calm && n_sent < CALM_FROM && $urandom_range(0, 3) == 0)
          idle_for($urandom_range(1, 15));
        send_job(make_job(mode, k == set_len - 1));
      end
      n_sets++;
      if (n_sets % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS nonpreemptive_priority_scheduler_top");
    end else begin
      if (sb.pending_results.size() != 0)
        $error("%0d results never arrived", sb.pending_results.size());
      $display("FAIL nonpreemptive_priority_scheduler_top");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL nonpreemptive_priority_scheduler_top");
    $finish;
  end

endmodule
